// ===== rtl/core/bdq_pkg.sv =====
package bdq_pkg;

  localparam int unsigned CmdW    = 3;
  localparam int unsigned StatusW = 2;
  localparam int unsigned WordW   = 32;

  typedef enum logic [CmdW-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_COUNT      = 3'd4,
    CMD_ERASE      = 3'd5
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_FETCH_F,
    S_FETCH_B,
    S_FETCH_W,
    S_DONE
  } state_e;

endpackage

// ===== rtl/core/bdq_ram.sv =====
module bdq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/core/bounded_deque_with_value_erase.sv =====
// Push, pop and unused codes: execute, two store reads, one wait, then output; when the queue
// ends up empty, also for a pop or erase on an empty queue, the second read and the wait are skipped.
// Count, and erase on a non-empty queue: a scan of the occupied entries, one entry read and compared
// per cycle on the single read port, before the same fetch and output steps. A new item is accepted
// only after the previous result is loaded into the output register.
// Reset (asynchronous, active low) empties the queue; store contents are not cleared.
module bounded_deque_with_value_erase #(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned CntW     = $clog2(DEPTH + 1),
  localparam int unsigned OutDataW = ((3 * 32 + 1 + CntW + 7) / 8) * 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // value[31:0]
  input  logic [31:0]                  s_axis_tdata,
  // command[2:0]
  input  logic [bdq_pkg::CmdW-1:0]     s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // data[31:0], occupancy, is_empty, front_word[31:0], back_word[31:0], zero pad
  output logic [OutDataW-1:0]          m_axis_tdata,
  // status[1:0]
  output logic [bdq_pkg::StatusW-1:0]  m_axis_tuser
);
  import bdq_pkg::*;

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam logic [PtrW:0]   DepthP = (PtrW + 1)'(DEPTH);
  localparam logic [CntW-1:0] DepthC = CntW'(DEPTH);
  localparam logic [PtrW-1:0] LastP  = PtrW'(DEPTH - 1);

  function automatic logic [PtrW-1:0] slot(input logic [PtrW-1:0] base,
                                           input logic [PtrW-1:0] off);
    logic [PtrW:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= DepthP) begin
      s = s - DepthP;
    end
    return s[PtrW-1:0];
  endfunction

  state_e state_q, state_d;

  logic [CmdW-1:0]  cmd_q, cmd_d;
  logic [WordW-1:0] val_q, val_d;
  logic [PtrW-1:0]  front_q, front_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  rd_idx_q, rd_idx_d;
  logic [CntW-1:0]  kept_q, kept_d;
  logic             pend_q, pend_d;
  status_e          status_q, status_d;
  logic [WordW-1:0] res_q, res_d;
  logic [WordW-1:0] fw_q, fw_d;
  logic [WordW-1:0] bw_q, bw_d;

  logic             out_valid_q, out_valid_d;
  status_e          o_status_q, o_status_d;
  logic [WordW-1:0] o_data_q, o_data_d;
  logic [CntW-1:0]  o_occ_q, o_occ_d;
  logic [WordW-1:0] o_fw_q, o_fw_d;
  logic [WordW-1:0] o_bw_q, o_bw_d;

  logic             ram_we;
  logic [PtrW-1:0]  ram_waddr;
  logic [WordW-1:0] ram_wdata;
  logic [PtrW-1:0]  ram_raddr;
  logic [WordW-1:0] ram_rdata;

  logic            is_full, is_emp, scan_done, out_load;
  logic [CntW-1:0] cnt_m1;

  assign is_full   = (count_q == DepthC);
  assign is_emp    = (count_q == '0);
  assign cnt_m1    = count_q - CntW'(1);
  assign scan_done = (rd_idx_q == count_q) && !pend_q;
  assign out_load  = !out_valid_q || m_axis_tready;

  bdq_ram #(
    .Width(WordW),
    .Depth(DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd_q == CMD_COUNT || (cmd_q == CMD_ERASE && !is_emp)) begin
          state_d = S_SCAN;
        end else begin
          state_d = S_FETCH_F;
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          state_d = S_FETCH_F;
        end
      end
      S_FETCH_F: begin
        state_d = is_emp ? S_DONE : S_FETCH_B;
      end
      S_FETCH_B: state_d = S_FETCH_W;
      S_FETCH_W: state_d = S_DONE;
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    cmd_d       = cmd_q;
    val_d       = val_q;
    front_d     = front_q;
    count_d     = count_q;
    rd_idx_d    = rd_idx_q;
    kept_d      = kept_q;
    pend_d      = pend_q;
    status_d    = status_q;
    res_d       = res_q;
    fw_d        = fw_q;
    bw_d        = bw_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    o_status_d  = o_status_q;
    o_data_d    = o_data_q;
    o_occ_d     = o_occ_q;
    o_fw_d      = o_fw_q;
    o_bw_d      = o_bw_q;
    ram_we      = 1'b0;
    ram_waddr   = front_q;
    ram_wdata   = val_q;
    ram_raddr   = front_q;
    s_axis_tready = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        cmd_d = s_axis_tuser;
        val_d = s_axis_tdata;
      end
      S_EXEC: begin
        status_d = ST_OK;
        res_d    = '0;
        rd_idx_d = '0;
        kept_d   = '0;
        pend_d   = 1'b0;
        case (cmd_q)
          CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
            if (is_full) begin
              status_d = ST_OVERFLOW;
            end else begin
              ram_we  = 1'b1;
              count_d = count_q + CntW'(1);
              if (cmd_q == CMD_PUSH_FRONT) begin
                ram_waddr = (front_q == '0) ? LastP : front_q - PtrW'(1);
                front_d   = ram_waddr;
              end else begin
                ram_waddr = slot(front_q, count_q[PtrW-1:0]);
              end
            end
          end
          CMD_POP_FRONT, CMD_POP_BACK: begin
            if (is_emp) begin
              status_d = ST_UNDERFLOW;
            end else begin
              count_d = cnt_m1;
              if (cmd_q == CMD_POP_FRONT) begin
                res_d   = fw_q;
                front_d = (front_q == LastP) ? '0 : front_q + PtrW'(1);
              end else begin
                res_d = bw_q;
              end
            end
          end
          CMD_ERASE: begin
            if (is_emp) begin
              status_d = ST_UNDERFLOW;
            end
          end
          default: ;
        endcase
      end
      S_SCAN: begin
        // Issue the next read while the previous word comes back
        ram_raddr = slot(front_q, rd_idx_q[PtrW-1:0]);
        pend_d    = (rd_idx_q != count_q);
        if (rd_idx_q != count_q) begin
          rd_idx_d = rd_idx_q + CntW'(1);
        end
        if (pend_q) begin
          if (ram_rdata == val_q) begin
            res_d = res_q + WordW'(1);
          end else if (cmd_q == CMD_ERASE) begin
            // Compact: kept never passes the slot being read
            ram_we    = 1'b1;
            ram_waddr = slot(front_q, kept_q[PtrW-1:0]);
            ram_wdata = ram_rdata;
            kept_d    = kept_q + CntW'(1);
          end
        end
        if (scan_done && cmd_q == CMD_ERASE) begin
          count_d = kept_q;
        end
      end
      S_FETCH_F: begin
        ram_raddr = front_q;
        if (is_emp) begin
          fw_d = '0;
          bw_d = '0;
        end
      end
      S_FETCH_B: begin
        ram_raddr = slot(front_q, cnt_m1[PtrW-1:0]);
        fw_d      = ram_rdata;
      end
      S_FETCH_W: begin
        bw_d = ram_rdata;
      end
      S_DONE: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          o_status_d  = status_q;
          o_data_d    = res_q;
          o_occ_d     = count_q;
          o_fw_d      = fw_q;
          o_bw_d      = bw_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      front_q     <= '0;
      count_q     <= '0;
      rd_idx_q    <= '0;
      kept_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      fw_q        <= '0;
      bw_q        <= '0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      count_q     <= count_d;
      rd_idx_q    <= rd_idx_d;
      kept_q      <= kept_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      fw_q        <= fw_d;
      bw_q        <= bw_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    val_q      <= val_d;
    status_q   <= status_d;
    res_q      <= res_d;
    o_status_q <= o_status_d;
    o_data_q   <= o_data_d;
    o_occ_q    <= o_occ_d;
    o_fw_q     <= o_fw_d;
    o_bw_q     <= o_bw_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = o_status_q;
  assign m_axis_tdata  = OutDataW'({o_bw_q, o_fw_q, (o_occ_q == '0), o_occ_q, o_data_q});

endmodule

// ===== verif/bounded_deque_with_value_erase_checker.sv =====
module bounded_deque_with_value_erase_checker #(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned OccW     = $clog2(DEPTH + 1),
  localparam int unsigned OutDataW = ((3 * 32 + 1 + OccW + 7) / 8) * 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  logic [31:0]                 in_data_i,
  input  logic [bdq_pkg::CmdW-1:0]    in_user_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  logic [OutDataW-1:0]         out_data_i,
  input  logic [bdq_pkg::StatusW-1:0] out_user_i,
  output int unsigned                 fail_count_o,
  output int unsigned                 pending_o,
  output int unsigned                 checked_o,
  output int unsigned                 overflow_seen_o,
  output int unsigned                 underflow_seen_o,
  output int unsigned                 erased_words_o
);
  import bdq_pkg::*;

  typedef struct packed {
    status_e          status;
    logic [31:0]      data;
    logic [OccW-1:0]  occupancy;
    logic             is_empty;
    logic [31:0]      front_word;
    logic [31:0]      back_word;
  } reply_t;

  // front of the deque at index 0
  logic [31:0] deque_words[$];
  reply_t      awaited_replies[$];

  function automatic reply_t apply_command(logic [CmdW-1:0] cmd, logic [31:0] val);
    reply_t      r;
    logic [31:0] kept[$];
    r = '0;
    r.status = ST_OK;
    case (cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (deque_words.size() >= DEPTH) begin
          r.status = ST_OVERFLOW;
        end else if (cmd == CMD_PUSH_FRONT) begin
          deque_words.insert(0, val);
        end else begin
          deque_words.push_back(val);
        end
      end
      CMD_POP_FRONT: begin
        if (deque_words.size() == 0) begin
          r.status = ST_UNDERFLOW;
        end else begin
          r.data = deque_words[0];
          deque_words.delete(0);
        end
      end
      CMD_POP_BACK: begin
        if (deque_words.size() == 0) r.status = ST_UNDERFLOW;
        else r.data = deque_words.pop_back();
      end
      CMD_COUNT: begin
        foreach (deque_words[k]) if (deque_words[k] == val) r.data = r.data + 32'd1;
      end
      CMD_ERASE: begin
        if (deque_words.size() == 0) begin
          r.status = ST_UNDERFLOW;
        end else begin
          // keep survivors in order
          foreach (deque_words[k]) begin
            if (deque_words[k] == val) r.data = r.data + 32'd1;
            else kept.push_back(deque_words[k]);
          end
          deque_words = kept;
        end
      end
      default: ;
    endcase
    r.occupancy = OccW'(deque_words.size());
    r.is_empty  = (deque_words.size() == 0);
    if (deque_words.size() != 0) begin
      r.front_word = deque_words[0];
      r.back_word  = deque_words[$];
    end
    return r;
  endfunction

  task automatic compare_field(string name, logic [31:0] exp, logic [31:0] act);
    if (exp !== act) begin
      fail_count_o++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp, act);
    end
  endtask

  reply_t got;
  assign got.status     = status_e'(out_user_i);
  assign got.data       = out_data_i[31:0];
  assign got.occupancy  = out_data_i[32 +: OccW];
  assign got.is_empty   = out_data_i[32 + OccW];
  assign got.front_word = out_data_i[33 + OccW +: 32];
  assign got.back_word  = out_data_i[65 + OccW +: 32];

  initial begin
    fail_count_o     = 0;
    pending_o        = 0;
    checked_o        = 0;
    overflow_seen_o  = 0;
    underflow_seen_o = 0;
    erased_words_o   = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    reply_t want;
    if (!rst_ni) begin
      deque_words.delete();
      awaited_replies.delete();
      pending_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (awaited_replies.size() == 0) begin
          fail_count_o++;
          $display("%0t: unexpected result, expected none, actual %h status %0d",
                   $time, out_data_i, out_user_i);
        end else begin
          want = awaited_replies[0];
          awaited_replies.delete(0);
          checked_o++;
          compare_field("status", 32'(want.status), 32'(got.status));
          compare_field("data", want.data, got.data);
          compare_field("occupancy", 32'(want.occupancy), 32'(got.occupancy));
          compare_field("is_empty", 32'(want.is_empty), 32'(got.is_empty));
          compare_field("front_word", want.front_word, got.front_word);
          compare_field("back_word", want.back_word, got.back_word);
        end
      end
      if (in_valid_i && in_ready_i) begin
        want = apply_command(in_user_i, in_data_i);
        if (want.status == ST_OVERFLOW) overflow_seen_o++;
        if (want.status == ST_UNDERFLOW) underflow_seen_o++;
        if (in_user_i == CMD_ERASE) erased_words_o += want.data;
        awaited_replies.push_back(want);
      end
      pending_o = awaited_replies.size();
    end
  end

endmodule

// ===== verif/bounded_deque_with_value_erase_test.sv =====
module bounded_deque_with_value_erase_test;
  import bdq_pkg::*;

  localparam int unsigned DEPTH    = 16;
  localparam int unsigned OccW     = $clog2(DEPTH + 1);
  localparam int unsigned OutDataW = ((3 * 32 + 1 + OccW + 7) / 8) * 8;

  // command codes the block leaves unused
  localparam logic [CmdW-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [CmdW-1:0] CMD_SPARE_HI = 3'd7;

  localparam int unsigned RAND_BLOCKS = 17;
  localparam int unsigned BLOCK_ITEMS = 60;

  typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} mix_e;

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [31:0]         s_axis_tdata = '0;
  logic [CmdW-1:0]     s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [StatusW-1:0]  m_axis_tuser;

  logic        src_stalls  = 1'b1;
  logic        sink_stalls = 1'b1;
  int unsigned items_sent  = 0;

  int unsigned fail_count, pending, checked, overflow_seen, underflow_seen, erased_words;

  bounded_deque_with_value_erase #(.DEPTH(DEPTH)) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  bounded_deque_with_value_erase_checker #(.DEPTH(DEPTH)) checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (s_axis_tvalid),
    .in_ready_i       (s_axis_tready),
    .in_data_i        (s_axis_tdata),
    .in_user_i        (s_axis_tuser),
    .out_valid_i      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .out_data_i       (m_axis_tdata),
    .out_user_i       (m_axis_tuser),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .checked_o        (checked),
    .overflow_seen_o  (overflow_seen),
    .underflow_seen_o (underflow_seen),
    .erased_words_o   (erased_words)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("%0t: timeout with %0d results outstanding", $time, pending);
    $display("Regression FAIL");
    $finish;
  end

  always @(posedge clk_i) begin
    if (!rst_ni) m_axis_tready <= 1'b0;
    else if (sink_stalls) m_axis_tready <= ($urandom_range(99) >= 12);
    else m_axis_tready <= 1'b1;
  end

  task automatic send_item(input logic [CmdW-1:0] cmd, input logic [31:0] val);
    if (src_stalls && $urandom_range(99) < 12) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= val;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      4: return 32'($urandom_range(9));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CmdW-1:0] pick_command(mix_e mix);
    int unsigned r, push_lim, count_lim, erase_lim;
    r = $urandom_range(99);
    case (mix)
      MODE_FILL:  begin push_lim = 55; count_lim = 70; erase_lim = 80; end
      MODE_DRAIN: begin push_lim = 25; count_lim = 35; erase_lim = 50; end
      default:    begin push_lim = 45; count_lim = 60; erase_lim = 75; end
    endcase
    if (r < push_lim) return $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
    if (r < count_lim) return CMD_COUNT;
    if (r < erase_lim) return CMD_ERASE;
    if (r < 97) return $urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT;
    return $urandom_range(1) ? CMD_SPARE_HI : CMD_SPARE_LO;
  endfunction

  initial begin
    logic [31:0] word_pool[4];
    logic [31:0] val;
    mix_e        mix;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty queue corner cases and unused codes
    send_item(CMD_POP_FRONT, 32'h1234_5678);
    send_item(CMD_POP_BACK, 32'h0);
    send_item(CMD_ERASE, 32'h0);
    send_item(CMD_COUNT, 32'h0);
    send_item(CMD_SPARE_LO, 32'hFFFF_FFFF);
    send_item(CMD_SPARE_HI, 32'h8000_0000);

    // fill to full from both ends with extremes and repeats
    for (int k = 0; k < DEPTH; k++) begin
      case (k % 4)
        0: val = 32'h8000_0000;
        1: val = 32'h7FFF_FFFF;
        2: val = 32'hFFFF_FFFF;
        default: val = 32'h0000_0000;
      endcase
      send_item(k[0] ? CMD_PUSH_BACK : CMD_PUSH_FRONT, val);
    end
    send_item(CMD_PUSH_FRONT, 32'h5555_5555);
    send_item(CMD_PUSH_BACK, 32'hAAAA_AAAA);
    send_item(CMD_COUNT, 32'hFFFF_FFFF);
    send_item(CMD_ERASE, 32'h7FFF_FFFF);
    send_item(CMD_POP_FRONT, 32'h0);
    send_item(CMD_POP_BACK, 32'h0);

    for (int b = 0; b < RAND_BLOCKS; b++) begin
      // run a few blocks with neither side stalling
      src_stalls  = !(b >= 6 && b <= 8);
      sink_stalls = src_stalls;
      mix = mix_e'(b % 3);
      foreach (word_pool[i]) word_pool[i] = pick_word();
      for (int n = 0; n < BLOCK_ITEMS; n++) begin
        // mostly pooled values so counts and erases find matches
        val = ($urandom_range(99) < 65) ? word_pool[$urandom_range(3)] : $urandom;
        send_item(pick_command(mix), val);
      end
    end
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("Sent %0d commands and checked %0d results across fill, drain and mixed phases.",
             items_sent, checked);
    $display("Saw %0d overflows, %0d underflows and %0d erased words.",
             overflow_seen, underflow_seen, erased_words);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/bdq_pkg.sv
rtl/core/bdq_ram.sv
rtl/core/bounded_deque_with_value_erase.sv
verif/bounded_deque_with_value_erase_checker.sv
verif/bounded_deque_with_value_erase_test.sv
